>>> src/rar_pkg.sv
// Shared types and constants for the axis-angle rotation matrix block.
// Holds the status codes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package rar_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_ROT    = 2'd1,
        ST_ZERO_AXIS = 2'd2
    } status_t;

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint TWO_PI_Q24  = 64'sd105414357;
    localparam longint TWO_PI_Q30  = TWO_PI_Q24 * 64;
    localparam longint PI_Q30      = TWO_PI_Q24 * 32;
    localparam longint HALF_PI_Q30 = TWO_PI_Q24 * 16;
    localparam longint CORDIC_GAIN = 64'sh26DD3B6A;

    // Pipeline depths of the axis path and of the matrix builder.
    localparam int NORM_LATENCY = 71;
    localparam int MAT_LATENCY  = 4;

    typedef struct packed {
        logic signed [33:0] cos_q30;
        logic signed [33:0] sin_q30;
        logic               angle_zero;
    } trig_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               axis_zero;
    } unit_axis_t;

    typedef logic [8:0][17:0] mat_t;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> src/rar_trig.sv
// Angle path: reduction modulo 2*pi, quadrant folding and a pipelined CORDIC.
// Depends on rar_pkg.
module rar_trig import rar_pkg::*; #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output trig_t              trig
);

    localparam logic [31:0] MOD_C4 = 32'(TWO_PI_Q24 * 16);
    localparam logic [31:0] MOD_C3 = 32'(TWO_PI_Q24 * 8);
    localparam logic [31:0] MOD_C2 = 32'(TWO_PI_Q24 * 4);
    localparam logic [31:0] MOD_C1 = 32'(TWO_PI_Q24 * 2);
    localparam logic [31:0] MOD_C0 = 32'(TWO_PI_Q24);
    localparam logic signed [34:0] PI_W      = 35'(PI_Q30);
    localparam logic signed [34:0] TWO_PI_W  = 35'(TWO_PI_Q30);
    localparam logic signed [33:0] PI_N      = 34'(PI_Q30);
    localparam logic signed [33:0] HALF_PI_N = 34'(HALF_PI_Q30);

    logic        sign1_reg, sign2_reg, sign3_reg;
    logic [31:0] mag1_reg, rem2_reg;
    logic [26:0] rem3_reg;
    logic signed [33:0] th4_reg;
    logic        zero4_reg;

    logic [31:0] rem2_next, rem3_full;
    logic signed [27:0] r_signed;
    logic signed [34:0] th_wide, th4_next;
    logic signed [33:0] z5_next;
    logic        flip5_next;

    logic signed [33:0] cx_reg [0:CORDIC_STEPS];
    logic signed [33:0] sy_reg [0:CORDIC_STEPS];
    logic signed [33:0] z_reg  [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];
    logic               zero_reg [0:CORDIC_STEPS];
    trig_t              trig_reg;

    always_comb begin
        rem2_next = mag1_reg;
        if (rem2_next >= MOD_C4) rem2_next = rem2_next - MOD_C4;
        if (rem2_next >= MOD_C3) rem2_next = rem2_next - MOD_C3;
        rem3_full = rem2_reg;
        if (rem3_full >= MOD_C2) rem3_full = rem3_full - MOD_C2;
        if (rem3_full >= MOD_C1) rem3_full = rem3_full - MOD_C1;
        if (rem3_full >= MOD_C0) rem3_full = rem3_full - MOD_C0;
    end

    // Remainder takes the sign of the angle, then wraps into [-pi, pi].
    always_comb begin
        r_signed = sign3_reg ? -$signed({1'b0, rem3_reg}) : $signed({1'b0, rem3_reg});
        th_wide  = 35'(r_signed) <<< 6;
        th4_next = th_wide;
        if (th_wide > PI_W) begin
            th4_next = th_wide - TWO_PI_W;
        end else if (th_wide < -PI_W) begin
            th4_next = th_wide + TWO_PI_W;
        end
    end

    // A fold by pi negates both sine and cosine at the end.
    always_comb begin
        z5_next    = th4_reg;
        flip5_next = 1'b0;
        if (th4_reg > HALF_PI_N) begin
            z5_next    = th4_reg - PI_N;
            flip5_next = 1'b1;
        end else if (th4_reg < -HALF_PI_N) begin
            z5_next    = th4_reg + PI_N;
            flip5_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign1_reg   <= angle[31];
            mag1_reg    <= angle[31] ? (~angle + 32'd1) : angle;
            sign2_reg   <= sign1_reg;
            rem2_reg    <= rem2_next;
            sign3_reg   <= sign2_reg;
            rem3_reg    <= rem3_full[26:0];
            th4_reg     <= 34'(th4_next);
            zero4_reg   <= (rem3_reg == 27'd0);
            cx_reg[0]   <= 34'(CORDIC_GAIN);
            sy_reg[0]   <= 34'sd0;
            z_reg[0]    <= z5_next;
            flip_reg[0] <= flip5_next;
            zero_reg[0] <= zero4_reg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        localparam logic signed [33:0] ATAN = 34'(atan_q30(i));
        logic signed [33:0] dx, dy;
        assign dx = sy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    sy_reg[i+1] <= sy_reg[i] + dy;
                    z_reg[i+1]  <= z_reg[i] - ATAN;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    sy_reg[i+1] <= sy_reg[i] - dy;
                    z_reg[i+1]  <= z_reg[i] + ATAN;
                end
                flip_reg[i+1] <= flip_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            trig_reg.cos_q30    <= flip_reg[CORDIC_STEPS] ? -cx_reg[CORDIC_STEPS]
                                                          : cx_reg[CORDIC_STEPS];
            trig_reg.sin_q30    <= flip_reg[CORDIC_STEPS] ? -sy_reg[CORDIC_STEPS]
                                                          : sy_reg[CORDIC_STEPS];
            trig_reg.angle_zero <= zero_reg[CORDIC_STEPS];
        end
    end

    assign trig = trig_reg;

endmodule

>>> src/rar_norm.sv
// Axis path: magnitude, power-of-two prescale, bit-serial square root and
// a three-lane restoring divide to a signed Q30 unit vector.
// Depends on rar_pkg.
module rar_norm import rar_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output unit_axis_t         unit
);

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic             zero;
    } ax_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
        ax_t         ax;
    } sq_t;

    typedef struct packed {
        logic [2:0][62:0] rem;
        logic [2:0][30:0] q;
        logic [31:0]      norm;
        logic [2:0]       neg;
        logic             zero;
    } dv_t;

    localparam logic [30:0] Q_ONE = 31'h40000000;

    ax_t         ax1_reg, ax2_reg, ax3_reg, ax4_reg, ax5_reg;
    logic [31:0] mx2_reg, mx3_reg;
    logic [2:0][63:0] sq5_reg;
    sq_t         sqr_reg [0:32];
    dv_t         div_reg [0:31];
    unit_axis_t  unit_reg;

    ax_t         ax1_next, ax3_next, ax4_next, ax2_next;
    logic [31:0] mx2_next, mx3_next, cur4;
    dv_t         div0_next;

    always_comb begin
        ax1_next.neg  = {axis_z[31], axis_y[31], axis_x[31]};
        ax1_next.mag[0] = axis_x[31] ? (~axis_x + 32'd1) : axis_x;
        ax1_next.mag[1] = axis_y[31] ? (~axis_y + 32'd1) : axis_y;
        ax1_next.mag[2] = axis_z[31] ? (~axis_z + 32'd1) : axis_z;
        ax1_next.zero = (axis_x == 32'sd0) && (axis_y == 32'sd0) && (axis_z == 32'sd0);
    end

    always_comb begin
        ax2_next = ax1_reg;
        mx2_next = (ax1_reg.mag[0] > ax1_reg.mag[1]) ? ax1_reg.mag[0] : ax1_reg.mag[1];
        if (ax1_reg.mag[2] > mx2_next) mx2_next = ax1_reg.mag[2];
    end

    // Largest left shift that keeps the biggest component below 2^31.
    always_comb begin
        ax3_next = ax2_reg;
        mx3_next = mx2_reg;
        if (mx3_next[31:15] == '0) begin
            mx3_next = mx3_next << 16;
            for (int i = 0; i < 3; i++) ax3_next.mag[i] = ax3_next.mag[i] << 16;
        end
        if (mx3_next[31:23] == '0) begin
            mx3_next = mx3_next << 8;
            for (int i = 0; i < 3; i++) ax3_next.mag[i] = ax3_next.mag[i] << 8;
        end
    end

    always_comb begin
        ax4_next = ax3_reg;
        cur4     = mx3_reg;
        if (cur4[31:27] == '0) begin
            cur4 = cur4 << 4;
            for (int i = 0; i < 3; i++) ax4_next.mag[i] = ax4_next.mag[i] << 4;
        end
        if (cur4[31:29] == '0) begin
            cur4 = cur4 << 2;
            for (int i = 0; i < 3; i++) ax4_next.mag[i] = ax4_next.mag[i] << 2;
        end
        if (cur4[31:30] == '0) begin
            for (int i = 0; i < 3; i++) ax4_next.mag[i] = ax4_next.mag[i] << 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= ax1_next;
            ax2_reg <= ax2_next;
            mx2_reg <= mx2_next;
            ax3_reg <= ax3_next;
            mx3_reg <= mx3_next;
            ax4_reg <= ax4_next;
            ax5_reg <= ax4_reg;
            for (int i = 0; i < 3; i++) begin
                sq5_reg[i] <= 64'(ax4_reg.mag[i]) * 64'(ax4_reg.mag[i]);
            end
            sqr_reg[0].v  <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            sqr_reg[0].r  <= 64'd0;
            sqr_reg[0].ax <= ax5_reg;
        end
    end

    for (genvar j = 0; j < 32; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        assign trial = sqr_reg[j].r + BIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                sqr_reg[j+1].ax <= sqr_reg[j].ax;
                if (sqr_reg[j].v >= trial) begin
                    sqr_reg[j+1].v <= sqr_reg[j].v - trial;
                    sqr_reg[j+1].r <= (sqr_reg[j].r >> 1) + BIT;
                end else begin
                    sqr_reg[j+1].v <= sqr_reg[j].v;
                    sqr_reg[j+1].r <= sqr_reg[j].r >> 1;
                end
            end
        end
    end

    // Dividend carries half the divisor so the quotient rounds to nearest.
    always_comb begin
        div0_next.norm = sqr_reg[32].r[31:0];
        div0_next.neg  = sqr_reg[32].ax.neg;
        div0_next.zero = sqr_reg[32].ax.zero;
        div0_next.q    = '0;
        for (int i = 0; i < 3; i++) begin
            div0_next.rem[i] = {sqr_reg[32].ax.mag[i], 30'd0}
                             + 63'(sqr_reg[32].r[31:1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) div_reg[0] <= div0_next;
    end

    for (genvar j = 0; j < 31; j++) begin : g_div
        localparam int B = 30 - j;
        logic [62:0] dsr;
        assign dsr = 63'(div_reg[j].norm) << B;
        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[j+1].norm <= div_reg[j].norm;
                div_reg[j+1].neg  <= div_reg[j].neg;
                div_reg[j+1].zero <= div_reg[j].zero;
                for (int i = 0; i < 3; i++) begin
                    if (div_reg[j].rem[i] >= dsr) begin
                        div_reg[j+1].rem[i]  <= div_reg[j].rem[i] - dsr;
                        div_reg[j+1].q[i]    <= div_reg[j].q[i] | (31'd1 << B);
                    end else begin
                        div_reg[j+1].rem[i]  <= div_reg[j].rem[i];
                        div_reg[j+1].q[i]    <= div_reg[j].q[i];
                    end
                end
            end
        end
    end

    function automatic logic signed [31:0] to_unit(input logic [30:0] q, input logic neg);
        logic [31:0] c;
        c = (q > Q_ONE) ? {1'b0, Q_ONE} : {1'b0, q};
        return neg ? -$signed(c) : $signed(c);
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            unit_reg.x         <= to_unit(div_reg[31].q[0], div_reg[31].neg[0]);
            unit_reg.y         <= to_unit(div_reg[31].q[1], div_reg[31].neg[1]);
            unit_reg.z         <= to_unit(div_reg[31].q[2], div_reg[31].neg[2]);
            unit_reg.axis_zero <= div_reg[31].zero;
        end
    end

    assign unit = unit_reg;

endmodule

>>> src/rar_matrix.sv
// Rotation matrix builder: Q30 products, entry sums and output rounding.
// Depends on rar_pkg.
module rar_matrix import rar_pkg::*; #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic       aclk,
    input  logic       en,
    input  trig_t      trig,
    input  unit_axis_t unit,
    output mat_t       mat,
    output status_t    status
);

    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [36:0] RND  = (SH > 0) ? (37'sd1 <<< (SH - 1)) : 37'sd0;
    localparam logic signed [36:0] OMAX = 37'sd131071;
    localparam logic signed [36:0] OMIN = -37'sd131072;

    function automatic logic signed [34:0] qmul(input logic signed [34:0] a,
                                                input logic signed [34:0] b);
        logic signed [69:0] p;
        p = 70'(a) * 70'(b);
        return 35'(p >>> 30);
    endfunction

    function automatic logic [17:0] to_out(input logic signed [35:0] v);
        logic signed [36:0] w;
        w = (37'(v) + RND) >>> SH;
        if (w > OMAX) return 18'h1FFFF;
        if (w < OMIN) return 18'h20000;
        return w[17:0];
    endfunction

    logic signed [34:0] tx1_reg, ty1_reg, tz1_reg, sx1_reg, sy1_reg, sz1_reg;
    logic signed [34:0] c1_reg, x1_reg, y1_reg, z1_reg;
    logic signed [34:0] txx2_reg, txy2_reg, txz2_reg, tyy2_reg, tyz2_reg, tzz2_reg;
    logic signed [34:0] sx2_reg, sy2_reg, sz2_reg, c2_reg;
    logic signed [35:0] e3_reg [0:8];
    mat_t               mat_reg;
    status_t            st1_reg, st2_reg, st3_reg, st4_reg;

    logic signed [34:0] t_q, ux, uy, uz;
    status_t            st1_next;

    always_comb begin
        t_q = 35'(ONE_Q30) - 35'(trig.cos_q30);
        ux  = 35'(unit.x);
        uy  = 35'(unit.y);
        uz  = 35'(unit.z);
        priority if (trig.angle_zero) st1_next = ST_NO_ROT;
        else if (unit.axis_zero)      st1_next = ST_ZERO_AXIS;
        else                          st1_next = ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx1_reg <= qmul(t_q, ux);
            ty1_reg <= qmul(t_q, uy);
            tz1_reg <= qmul(t_q, uz);
            sx1_reg <= qmul(35'(trig.sin_q30), ux);
            sy1_reg <= qmul(35'(trig.sin_q30), uy);
            sz1_reg <= qmul(35'(trig.sin_q30), uz);
            c1_reg  <= 35'(trig.cos_q30);
            x1_reg  <= ux;
            y1_reg  <= uy;
            z1_reg  <= uz;
            st1_reg <= st1_next;

            txx2_reg <= qmul(tx1_reg, x1_reg);
            txy2_reg <= qmul(tx1_reg, y1_reg);
            txz2_reg <= qmul(tx1_reg, z1_reg);
            tyy2_reg <= qmul(ty1_reg, y1_reg);
            tyz2_reg <= qmul(ty1_reg, z1_reg);
            tzz2_reg <= qmul(tz1_reg, z1_reg);
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
            sz2_reg  <= sz1_reg;
            c2_reg   <= c1_reg;
            st2_reg  <= st1_reg;

            e3_reg[0] <= 36'(txx2_reg) + 36'(c2_reg);
            e3_reg[1] <= 36'(txy2_reg) + 36'(sz2_reg);
            e3_reg[2] <= 36'(txz2_reg) - 36'(sy2_reg);
            e3_reg[3] <= 36'(txy2_reg) - 36'(sz2_reg);
            e3_reg[4] <= 36'(tyy2_reg) + 36'(c2_reg);
            e3_reg[5] <= 36'(tyz2_reg) + 36'(sx2_reg);
            e3_reg[6] <= 36'(txz2_reg) + 36'(sy2_reg);
            e3_reg[7] <= 36'(tyz2_reg) - 36'(sx2_reg);
            e3_reg[8] <= 36'(tzz2_reg) + 36'(c2_reg);
            st3_reg   <= st2_reg;

            for (int i = 0; i < 9; i++) mat_reg[i] <= to_out(e3_reg[i]);
            st4_reg <= st3_reg;
        end
    end

    assign mat    = mat_reg;
    assign status = st4_reg;

endmodule

>>> src/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix, streaming top level.
// Depends on rar_pkg, rar_trig, rar_norm and rar_matrix.
//
// Each input item carries a Q16.16 axis and a Q8.24 angle in radians. The
// block answers with two result items, the forward matrix (matrix_kind 0) and
// then its transpose, the matrix for the negated angle (matrix_kind 1, tlast
// set). An angle that reduces to zero modulo 2*pi gives a single item with
// status no_rotation, and otherwise a zero axis gives a single item with status
// zero_axis; both carry a zero matrix and tlast. Entries are signed with
// OUT_FRAC_BITS fraction bits, rounded half up and saturated to 18 bits. The
// datapath is one pipeline that takes an item in every cycle while not held.
// The axis path, with the 32-stage square root and the 31-stage divide, is
// the longer one; the angle path (CORDIC_STEPS + 6 stages) runs beside it
// and is delayed to line up. A good item leaves as two result items, so the
// block takes no new item while its forward matrix waits. The pipeline
// holds while the output register still has a result to deliver, and
// s_tready follows that hold. s_tready is low while reset is asserted.
module axis_angle_rotation_matrix import rar_pkg::*; #(
    parameter int CORDIC_STEPS  = 18,
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // axis_x [31:0], axis_y [63:32], axis_z [95:64], angle [127:96]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r0_c0 [17:0], r0_c1, r0_c2, r1_c0, r1_c1, r1_c2, r2_c0, r2_c1,
    // r2_c2 [161:144], zero fill [167:162]
    output logic [167:0] m_tdata,
    // matrix_kind [0], status [2:1]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int TRIG_LATENCY = CORDIC_STEPS + 6;
    localparam int DLY          = NORM_LATENCY - TRIG_LATENCY;
    localparam int TOTAL        = NORM_LATENCY + MAT_LATENCY;

    logic              en;
    logic [TOTAL-1:0]  vld_reg;
    trig_t             trig_raw;
    trig_t             trig_dly_reg [0:DLY-1];
    unit_axis_t        unit;
    mat_t              mat_out;
    status_t           status_out;

    logic              out_valid_reg;
    logic              phase_reg;
    mat_t              mat_reg;
    status_t           status_reg;
    logic              out_last;

    // The whole pipeline moves only when the output register is free or is
    // handing over its final result in this cycle.
    assign out_last = (status_reg != ST_OK) || phase_reg;
    assign en       = !out_valid_reg || (m_tready && out_last);
    assign s_tready = en && aresetn;

    rar_trig #(.CORDIC_STEPS(CORDIC_STEPS)) u_trig (
        .aclk  (aclk),
        .en    (en),
        .angle ($signed(s_tdata[127:96])),
        .trig  (trig_raw)
    );

    rar_norm u_norm (
        .aclk   (aclk),
        .en     (en),
        .axis_x ($signed(s_tdata[31:0])),
        .axis_y ($signed(s_tdata[63:32])),
        .axis_z ($signed(s_tdata[95:64])),
        .unit   (unit)
    );

    // The angle path is shorter; its results wait here for the unit axis.
    always_ff @(posedge aclk) begin
        if (en) begin
            trig_dly_reg[0] <= trig_raw;
            for (int i = 1; i < DLY; i++) trig_dly_reg[i] <= trig_dly_reg[i-1];
        end
    end

    rar_matrix #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_matrix (
        .aclk   (aclk),
        .en     (en),
        .trig   (trig_dly_reg[DLY-1]),
        .unit   (unit),
        .mat    (mat_out),
        .status (status_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[TOTAL-2:0], s_tvalid};
            out_valid_reg <= vld_reg[TOTAL-1];
            phase_reg     <= 1'b0;
        end else if (m_tready) begin
            // Forward matrix taken; the transpose goes out next.
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg    <= mat_out;
            status_reg <= status_out;
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (status_reg == ST_OK) begin
                    m_tdata[(r*3+c)*18 +: 18] = phase_reg ? mat_reg[c*3+r] : mat_reg[r*3+c];
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {status_reg, phase_reg};
    assign m_tlast  = out_last;

endmodule

>>> src/rar_checker.sv
// Port-level checks for axis_angle_rotation_matrix, bound to the top level.
// Depends only on the top level's ports.
module rar_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);

    // A stalled result item holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // The inverse matrix only follows a good rotation and ends the run.
    a_inverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == 2'd0 && m_tlast)
        else $error("inverse matrix with bad status or without tlast");

    // Error and no-rotation items are single, forward and all zero.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != 2'd0 |-> m_tlast && !m_tuser[0] && m_tdata == '0)
        else $error("non-ok result item is not a lone zero item");

    // Once the forward matrix is taken, its transpose is offered at once.
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0])
        else $error("transpose did not follow the forward matrix");

endmodule

bind axis_angle_rotation_matrix rar_checker u_rar_checker (.*);
